FILE: sv/spq_pkg.sv
package spq_pkg;

   localparam int PRIO_WIDTH      = 16;
   localparam int PORT_DATA_WIDTH = 32;
   localparam int COUNT_WIDTH     = 5;
   localparam int CAPACITY_DEF    = 16;
   localparam int DATA_WIDTH_DEF  = 32;

   typedef enum logic {
      KIND_ADD = 1'b0,
      KIND_POP = 1'b1
   } kind_type;

   // one beat's action, broadcast along the chain
   typedef struct packed {
      logic insert;
      logic pop;
   } spq_ctrl_type;

endpackage

FILE: sv/spq_cell.sv
module spq_cell #(
   parameter int STORE_WIDTH = 32
) (
   input  logic                         clock,
   input  spq_pkg::spq_ctrl_type        ctrl,
   input  logic                         occupied,
   input  logic [spq_pkg::PRIO_WIDTH-1:0] new_prio,
   input  logic [STORE_WIDTH-1:0]       new_data,
   input  logic                         prev_at,
   input  logic [spq_pkg::PRIO_WIDTH-1:0] prev_prio,
   input  logic [STORE_WIDTH-1:0]       prev_data,
   input  logic [spq_pkg::PRIO_WIDTH-1:0] next_prio,
   input  logic [STORE_WIDTH-1:0]       next_data,
   output logic                         at,
   output logic [spq_pkg::PRIO_WIDTH-1:0] prio,
   output logic [STORE_WIDTH-1:0]       data
);
   import spq_pkg::*;

   logic [PRIO_WIDTH-1:0]  prio_ff, prio_in;
   logic [STORE_WIDTH-1:0] data_ff, data_in;

   // at: the new entry belongs here or further up front of this cell
   assign at = !occupied || (prio_ff > new_prio);

   always_comb begin
      prio_in = prio_ff;
      data_in = data_ff;
      priority if (ctrl.insert && at && prev_at) begin
         prio_in = prev_prio;
         data_in = prev_data;
      end else if (ctrl.insert && at) begin
         prio_in = new_prio;
         data_in = new_data;
      end else if (ctrl.pop) begin
         prio_in = next_prio;
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

   assign prio = prio_ff;
   assign data = data_ff;

endmodule

FILE: sv/stable_priority_queue_unit.sv
// Channel   Direction  Beat contents
// req_      in         kind, priority_req, data_in
// rsp_      out        accepted, was_empty, data_out, priority_out, count, is_full
//
// One beat per cycle while the result register is free or being taken: every cell
// compares and shifts in the same cycle, and a taken request's result goes straight into the result register.
// Reset (synchronous, active high) empties the queue and drops any pending result.
// A stalled result holds the chain; req_ready stays high while the result
// register is empty or being taken.
module stable_priority_queue_unit #(
   parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [spq_pkg::PRIO_WIDTH-1:0]        req_priority_req,
   input  logic [spq_pkg::PORT_DATA_WIDTH-1:0]   req_data_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_accepted,
   output logic                                  rsp_was_empty,
   output logic [spq_pkg::PORT_DATA_WIDTH-1:0]   rsp_data_out,
   output logic [spq_pkg::PRIO_WIDTH-1:0]        rsp_priority_out,
   output logic [spq_pkg::COUNT_WIDTH-1:0]       rsp_count,
   output logic                                  rsp_is_full
);
   import spq_pkg::*;

   localparam int STORE_WIDTH = (DATA_WIDTH < PORT_DATA_WIDTH) ? DATA_WIDTH : PORT_DATA_WIDTH;
   localparam int CW          = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          full, empty, take;
   spq_ctrl_type  ctrl;

   logic                   at_w   [CAPACITY];
   logic [PRIO_WIDTH-1:0]  prio_w [CAPACITY];
   logic [STORE_WIDTH-1:0] data_w [CAPACITY];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       accepted_ff, accepted_in;
   logic                       was_empty_ff, was_empty_in;
   logic [PORT_DATA_WIDTH-1:0] data_out_ff, data_out_in;
   logic [PRIO_WIDTH-1:0]      prio_out_ff, prio_out_in;
   logic [COUNT_WIDTH-1:0]     count_out_ff, count_out_in;
   logic                       is_full_ff, is_full_in;
   logic [CW+COUNT_WIDTH-1:0]  count_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   // drop adds to a full queue and pops from an empty one
   assign ctrl.insert = take && (kind_type'(req_kind) == KIND_ADD) && !full;
   assign ctrl.pop    = take && (kind_type'(req_kind) == KIND_POP) && !empty;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                   prev_at;
         logic [PRIO_WIDTH-1:0]  prev_prio, next_prio;
         logic [STORE_WIDTH-1:0] prev_data, next_data;

         if (i == 0) begin : g_head
            assign prev_at   = 1'b0;
            assign prev_prio = '0;
            assign prev_data = '0;
         end else begin : g_mid
            assign prev_at   = at_w[i-1];
            assign prev_prio = prio_w[i-1];
            assign prev_data = data_w[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign next_prio = '0;
            assign next_data = '0;
         end else begin : g_body
            assign next_prio = prio_w[i+1];
            assign next_data = data_w[i+1];
         end

         spq_cell #(.STORE_WIDTH(STORE_WIDTH)) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .occupied  (CW'(i) < count_ff),
            .new_prio  (req_priority_req),
            .new_data  (req_data_in[STORE_WIDTH-1:0]),
            .prev_at   (prev_at),
            .prev_prio (prev_prio),
            .prev_data (prev_data),
            .next_prio (next_prio),
            .next_data (next_data),
            .at        (at_w[i]),
            .prio      (prio_w[i]),
            .data      (data_w[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_wide = {{COUNT_WIDTH{1'b0}}, count_in};

   // build the result beat from the state before the step and the new count
   always_comb begin
      accepted_in  = ctrl.insert || ctrl.pop;
      was_empty_in = (kind_type'(req_kind) == KIND_POP) && empty;
      data_out_in  = '0;
      prio_out_in  = '0;
      if (ctrl.pop) begin
         data_out_in[STORE_WIDTH-1:0] = data_w[0];
         prio_out_in                  = prio_w[0];
      end
      count_out_in = count_wide[COUNT_WIDTH-1:0];
      is_full_in   = (count_in == CW'(CAPACITY));
      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // hold the payload until a new beat is taken
      if (take) begin
         accepted_ff  <= accepted_in;
         was_empty_ff <= was_empty_in;
         data_out_ff  <= data_out_in;
         prio_out_ff  <= prio_out_in;
         count_out_ff <= count_out_in;
         is_full_ff   <= is_full_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_was_empty    = was_empty_ff;
   assign rsp_data_out     = data_out_ff;
   assign rsp_priority_out = prio_out_ff;
   assign rsp_count        = count_out_ff;
   assign rsp_is_full      = is_full_ff;

endmodule

FILE: sv/spq_checker.sv
module spq_assertions #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_accepted,
   input logic                                rsp_was_empty,
   input logic [spq_pkg::PORT_DATA_WIDTH-1:0] rsp_data_out,
   input logic [spq_pkg::PRIO_WIDTH-1:0]      rsp_priority_out,
   input logic [spq_pkg::COUNT_WIDTH-1:0]     rsp_count,
   input logic                                rsp_is_full
);
   import spq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
      else $error("result beat dropped or changed while stalled");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty result register");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_was_empty))
      else $error("beat both accepted and empty");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_empty |->
         rsp_data_out == '0 && rsp_priority_out == '0 && rsp_count == '0)
      else $error("empty pop carries data or nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_full |-> rsp_count == COUNT_WIDTH'(CAPACITY))
      else $error("full flag disagrees with count");

endmodule

bind stable_priority_queue_unit spq_assertions #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

FILE: tb/spq_checker.sv
module spq_checker #(
   parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [spq_pkg::PRIO_WIDTH-1:0]        req_priority_req,
   input  logic [spq_pkg::PORT_DATA_WIDTH-1:0]   req_data_in,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_accepted,
   input  logic                                  rsp_was_empty,
   input  logic [spq_pkg::PORT_DATA_WIDTH-1:0]   rsp_data_out,
   input  logic [spq_pkg::PRIO_WIDTH-1:0]        rsp_priority_out,
   input  logic [spq_pkg::COUNT_WIDTH-1:0]       rsp_count,
   input  logic                                  rsp_is_full,
   output int                                    fail_count,
   output int                                    outstanding
);

   localparam logic [63:0] MASK_WIDE =
      (DATA_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << DATA_WIDTH) - 64'd1);
   localparam logic [spq_pkg::PORT_DATA_WIDTH-1:0] STORE_MASK =
      MASK_WIDE[spq_pkg::PORT_DATA_WIDTH-1:0];

   typedef struct packed {
      logic                                accepted;
      logic                                was_empty;
      logic [spq_pkg::PORT_DATA_WIDTH-1:0] data_out;
      logic [spq_pkg::PRIO_WIDTH-1:0]      priority_out;
      logic [spq_pkg::COUNT_WIDTH-1:0]     count;
      logic                                is_full;
   } pq_result_t;

   logic [spq_pkg::PRIO_WIDTH-1:0]      held_prio [CAPACITY];
   logic [spq_pkg::PORT_DATA_WIDTH-1:0] held_data [CAPACITY];
   int                                  held_count;
   pq_result_t                          due_results [$];
   int                                  errors;

   // sorted insert behind equal priorities, or pop of the head
   function automatic pq_result_t queue_step(input logic kind,
                                             input logic [spq_pkg::PRIO_WIDTH-1:0] prio,
                                             input logic [spq_pkg::PORT_DATA_WIDTH-1:0] data);
      pq_result_t res;
      int         pos;
      res = '0;
      if (kind == spq_pkg::KIND_ADD) begin
         if (held_count < CAPACITY) begin
            pos = held_count;
            while (pos > 0 && held_prio[pos-1] > prio) begin
               held_prio[pos] = held_prio[pos-1];
               held_data[pos] = held_data[pos-1];
               pos--;
            end
            held_prio[pos] = prio;
            held_data[pos] = data & STORE_MASK;
            held_count++;
            res.accepted = 1'b1;
         end
      end else begin
         if (held_count == 0) begin
            res.was_empty = 1'b1;
         end else begin
            res.data_out     = held_data[0];
            res.priority_out = held_prio[0];
            for (int i = 1; i < held_count; i++) begin
               held_prio[i-1] = held_prio[i];
               held_data[i-1] = held_data[i];
            end
            held_count--;
            res.accepted = 1'b1;
         end
      end
      res.count   = held_count[spq_pkg::COUNT_WIDTH-1:0];
      res.is_full = (held_count == CAPACITY);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("rsp_%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   initial begin
      errors     = 0;
      held_count = 0;
   end

   always @(posedge clock) begin
      pq_result_t want;
      if (reset) begin
         held_count = 0;
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("rsp beat with no request outstanding");
               errors++;
            end else begin
               want = due_results.pop_front();
               check_field("accepted",     64'(want.accepted),     64'(rsp_accepted));
               check_field("was_empty",    64'(want.was_empty),    64'(rsp_was_empty));
               check_field("data_out",     64'(want.data_out),     64'(rsp_data_out));
               check_field("priority_out", 64'(want.priority_out), 64'(rsp_priority_out));
               check_field("count",        64'(want.count),        64'(rsp_count));
               check_field("is_full",      64'(want.is_full),      64'(rsp_is_full));
            end
         end
         if (req_valid && req_ready)
            due_results.push_back(queue_step(req_kind, req_priority_req, req_data_in));
      end
      fail_count  <= errors;
      outstanding <= due_results.size();
   end

endmodule

FILE: tb/testbench.sv
module testbench;

   localparam int TOTAL_ITEMS = 1550;

   logic                                  clock;
   logic                                  reset     = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic                                  req_kind  = spq_pkg::KIND_ADD;
   logic [spq_pkg::PRIO_WIDTH-1:0]        req_priority_req = '0;
   logic [spq_pkg::PORT_DATA_WIDTH-1:0]   req_data_in      = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic                                  rsp_accepted;
   logic                                  rsp_was_empty;
   logic [spq_pkg::PORT_DATA_WIDTH-1:0]   rsp_data_out;
   logic [spq_pkg::PRIO_WIDTH-1:0]        rsp_priority_out;
   logic [spq_pkg::COUNT_WIDTH-1:0]       rsp_count;
   logic                                  rsp_is_full;

   int   fail_count;
   int   outstanding;
   int   sent;
   // when set, both sides run flat out with no gaps and no stalls
   logic calm = 1'b0;

   stable_priority_queue_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_was_empty    (rsp_was_empty),
      .rsp_data_out     (rsp_data_out),
      .rsp_priority_out (rsp_priority_out),
      .rsp_count        (rsp_count),
      .rsp_is_full      (rsp_is_full)
   );

   spq_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_was_empty    (rsp_was_empty),
      .rsp_data_out     (rsp_data_out),
      .rsp_priority_out (rsp_priority_out),
      .rsp_count        (rsp_count),
      .rsp_is_full      (rsp_is_full),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length in cycles: mostly none, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Present one request beat and hold it, payload unchanged, until the block takes it.
   // Valid is raised without looking at ready.
   task automatic send_beat(input logic kind, input logic [spq_pkg::PRIO_WIDTH-1:0] prio,
                            input logic [spq_pkg::PORT_DATA_WIDTH-1:0] data);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= prio;
      req_data_in      <= data;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Idle the request side for a random gap after an accepted beat.  With no gap
   // the next send_beat keeps valid high, so valid gets only one assignment per step.
   task automatic idle_req();
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_spaced(input logic kind, input logic [spq_pkg::PRIO_WIDTH-1:0] prio,
                              input logic [spq_pkg::PORT_DATA_WIDTH-1:0] data);
      send_beat(kind, prio, data);
      idle_req();
   endtask

   // Priority mix: a narrow band gives plenty of ties to test arrival order,
   // the rest spreads across the whole range and hits both extremes.
   function automatic logic [spq_pkg::PRIO_WIDTH-1:0] pick_prio();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return 16'($urandom_range(0, 7));
      else if (roll < 55)
         return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else if (roll < 65)
         return 16'(16'hFFF8 + $urandom_range(0, 7));
      else
         return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // Response side: accept by default, stall at random for gaps of the same
   // shape as the request side, never stall while calm.
   always @(posedge clock) begin
      int stall_left;
      int n;
      if (calm) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
         n = pick_gap();
         stall_left = (n > 0) ? n - 1 : 0;
         rsp_ready <= (n == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus
   initial begin
      int phase_len;
      int add_pct;
      logic kind;

      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop from an empty queue first.
      send_spaced(spq_pkg::KIND_POP, 16'h1234, 32'hDEAD_BEEF);
      // Extremes of priority and data, ties at the middle, at the top and at the bottom.
      send_spaced(spq_pkg::KIND_ADD, 16'h8000, 32'h0000_0000);
      send_spaced(spq_pkg::KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF);
      send_spaced(spq_pkg::KIND_ADD, 16'h0000, 32'h1234_5678);
      send_spaced(spq_pkg::KIND_ADD, 16'h8000, 32'hAAAA_AAAA);
      send_spaced(spq_pkg::KIND_ADD, 16'h8000, 32'h5555_5555);
      send_spaced(spq_pkg::KIND_ADD, 16'h0000, 32'hFFFF_FFFF);
      send_spaced(spq_pkg::KIND_ADD, 16'hFFFF, 32'h0000_0001);
      // Fill the rest, alternating complementary patterns, to reach a full queue.
      for (int i = 0; i < 9; i++)
         send_spaced(spq_pkg::KIND_ADD, i[0] ? 16'hAAAA : 16'h5555,
                     i[0] ? 32'h5555_5555 ^ i : 32'hAAAA_AAAA ^ i);
      // Add to a full queue: refused, nothing changes.
      send_spaced(spq_pkg::KIND_ADD, 16'h0000, 32'hCAFE_F00D);
      // Drain a few from the head to see the order come out.
      repeat (6) send_spaced(spq_pkg::KIND_POP, 16'hFFFF, 32'hFFFF_FFFF);

      // Random: phases leaning to fill, to drain or balanced, so the queue keeps
      // swinging between full and empty with random content in between.
      while (sent < TOTAL_ITEMS) begin
         phase_len = $urandom_range(20, 120);
         case ($urandom_range(0, 2))
            0: begin
               add_pct = 80;
            end
            1: begin
               add_pct = 20;
            end
            default: begin
               add_pct = 50;
            end
         endcase
         calm = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            if (sent < TOTAL_ITEMS) begin
               kind = ($urandom_range(0, 99) < add_pct) ? spq_pkg::KIND_ADD : spq_pkg::KIND_POP;
               send_spaced(kind, pick_prio(), $urandom());
            end
         end
      end

      // Drop valid and wait for every expected result, then a few cycles more
      // for anything stray.
      req_valid <= 1'b0;
      calm = 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
